FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL of the slot allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is held.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: design/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Opcodes, field widths and the table command shared by the slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

    localparam int OP_W       = 4;
    localparam int SLOT_W     = 5;   // width of a slot index on the request side
    localparam int TAG_W      = 16;  // width of the node tag ports
    localparam int AVOID_W    = 16;  // slots covered by the avoid mask
    localparam int OUT_SLOT_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 4'd0,
        OP_LOCK       = 4'd1,
        OP_UNLOCK     = 4'd2,
        OP_FIND       = 4'd3,
        OP_SET        = 4'd4,
        OP_GET        = 4'd5,
        OP_MARK_DIRTY = 4'd6,
        OP_MARK_CLEAN = 4'd7,
        OP_QUERY      = 4'd8,
        OP_ALLOC      = 4'd9,
        OP_INVAL_VOL  = 4'd10
    } t_opcode;

    // One cycle's worth of updates to the slot table.
    typedef struct packed {
        logic              clear_all;
        logic              inval_vol;
        logic              set_lock;
        logic              clr_lock;
        logic              write_node;
        logic              set_dirty;
        logic              clr_dirty;
        logic              evict;
        logic              dirty_val;
        logic [SLOT_W-1:0] idx;
        logic [SLOT_W-1:0] evict_idx;
    } t_tbl_cmd;

endpackage

`default_nettype wire

FILE: design/rsa_pri_enc.sv
// ----------------------------------------------------------------------------
// rsa_pri_enc
// Lowest-index priority encoder over a request vector.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_pri_enc #(
    parameter int N = 16
) (
    input  wire logic [N-1:0]         i_req,
    output      logic                 o_found,
    output      logic [$clog2(N)-1:0] o_idx
);

    localparam int IDX_W = $clog2(N);

    // Scan from the top so the lowest set bit wins.
    always_comb begin
        o_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_req[i]) begin
                o_idx = IDX_W'(i);
            end
        end
    end

    assign o_found = |i_req;

endmodule

`default_nettype wire

FILE: design/rsa_slot_table.sv
// ----------------------------------------------------------------------------
// rsa_slot_table
// Slot state (valid, lock, dirty, node tag) with tag search and read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_slot_table
    import rsa_pkg::*;
#(
    parameter int NUM_SLOTS      = 16,
    parameter int VOLATILE_COUNT = 6,
    parameter int NODE_BITS      = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_tbl_cmd             i_cmd,
    input  wire logic [NODE_BITS-1:0] i_tag,
    input  wire logic [SLOT_W-1:0]    i_rd_idx,
    output      logic [NUM_SLOTS-1:0] o_valid,
    output      logic [NUM_SLOTS-1:0] o_locked,
    output      logic [NUM_SLOTS-1:0] o_dirty,
    output      logic [NUM_SLOTS-1:0] o_match,
    output      logic [NODE_BITS-1:0] o_rd_node
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] r_valid;
    logic [NUM_SLOTS-1:0] r_locked;
    logic [NUM_SLOTS-1:0] r_dirty;
    logic [NODE_BITS-1:0] r_node [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] sel;
    logic [NUM_SLOTS-1:0] kill;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            sel[i]  = (i_cmd.idx == SLOT_W'(i));
            kill[i] = (i_cmd.inval_vol && (i < VOLATILE_COUNT))
                   || (i_cmd.evict && (i_cmd.evict_idx == SLOT_W'(i)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_valid  <= '0;
            r_locked <= '0;
            r_dirty  <= '0;
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (i_cmd.set_lock && sel[i]) begin
                    r_locked[i] <= 1'b1;
                end else if (i_cmd.clr_lock && sel[i]) begin
                    r_locked[i] <= 1'b0;
                end
                priority if (kill[i]) begin
                    r_valid[i] <= 1'b0;
                    r_dirty[i] <= 1'b0;
                end else if (i_cmd.write_node && sel[i]) begin
                    r_valid[i] <= 1'b1;
                    r_dirty[i] <= i_cmd.dirty_val;
                end else if (i_cmd.set_dirty && sel[i]) begin
                    r_dirty[i] <= 1'b1;
                end else if (i_cmd.clr_dirty && sel[i]) begin
                    r_dirty[i] <= 1'b0;
                end else begin
                    // hold valid and dirty
                end
            end
        end
    end

    // Tags are only read behind a valid bit, so they need no reset.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i_cmd.write_node && sel[i]) begin
                r_node[i] <= i_tag;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            o_match[i] = r_valid[i] && (r_node[i] == i_tag);
        end
    end

    assign o_valid   = r_valid;
    assign o_locked  = r_locked;
    assign o_dirty   = r_dirty;
    assign o_rd_node = r_node[i_rd_idx[IDX_W-1:0]];

endmodule

`default_nettype wire

FILE: design/register_slot_allocator.sv
// ----------------------------------------------------------------------------
// register_slot_allocator
// Slot table with lock, dirty, tag search and priority allocation/eviction.
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge where start is high and busy is
// low; busy is never raised, so one transaction enters per cycle. Each
// transaction is latched into the request register, executed against the
// slot table in the following cycle (tag compare across all slots and three
// lowest-index priority encoders), and its result is registered and shown on
// the o_ ports for exactly one cycle with o_valid high.
// Results cannot be held off by the receiver and need not be: every
// transaction retires in one pass, and a transaction sees all table updates
// made by the one before it.
// ----------------------------------------------------------------------------
`default_nettype none

module register_slot_allocator
    import rsa_pkg::*;
#(
    parameter int NUM_SLOTS      = 16,
    parameter int VOLATILE_COUNT = 6,
    parameter int NODE_BITS      = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic [OP_W-1:0]       i_opcode,
    input  wire logic [SLOT_W-1:0]     i_slot_index,
    input  wire logic [TAG_W-1:0]      i_node_tag,
    input  wire logic                  i_dirty_in,
    input  wire logic [AVOID_W-1:0]    i_avoid_mask,
    output      logic                  o_valid,
    output      logic                  o_hit,
    output      logic [OUT_SLOT_W-1:0] o_slot_out,
    output      logic [TAG_W-1:0]      o_node_out,
    output      logic                  o_dirty_out
);

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(NUM_SLOTS);

    // ---------------------------------------------------------------- request
    logic                  r_req_valid;
    logic [OP_W-1:0]       r_op;
    logic [SLOT_W-1:0]     r_idx;
    logic [TAG_W-1:0]      r_tag;
    logic                  r_din;
    logic [AVOID_W-1:0]    r_avoid;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= start && !busy;
        end
    end

    // Payload holds no reset; it is qualified by r_req_valid.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op    <= i_opcode;
            r_idx   <= i_slot_index;
            r_tag   <= i_node_tag;
            r_din   <= i_dirty_in;
            r_avoid <= i_avoid_mask;
        end
    end

    // ---------------------------------------------------------------- table
    t_tbl_cmd             cmd;
    logic [NODE_BITS-1:0] tag_st;
    logic [NUM_SLOTS-1:0] valid_vec;
    logic [NUM_SLOTS-1:0] locked_vec;
    logic [NUM_SLOTS-1:0] dirty_vec;
    logic [NUM_SLOTS-1:0] match_vec;
    logic [NODE_BITS-1:0] rd_node;

    // Mask the incoming tag down to NODE_BITS (or widen with zeros).
    always_comb begin
        logic [31:0] tag_ext;
        tag_ext = 32'(r_tag);
        tag_st  = tag_ext[NODE_BITS-1:0];
    end

    rsa_slot_table #(
        .NUM_SLOTS      (NUM_SLOTS),
        .VOLATILE_COUNT (VOLATILE_COUNT),
        .NODE_BITS      (NODE_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_tag     (tag_st),
        .i_rd_idx  (r_idx),
        .o_valid   (valid_vec),
        .o_locked  (locked_vec),
        .o_dirty   (dirty_vec),
        .o_match   (match_vec),
        .o_rd_node (rd_node)
    );

    // ---------------------------------------------------------------- search
    // Slots 16 and up have no avoid bit; only locks bar them.
    logic [NUM_SLOTS-1:0] barred;
    logic [NUM_SLOTS-1:0] free_vec;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            barred[i] = locked_vec[i] || ((i < AVOID_W) && r_avoid[i % AVOID_W]);
        end
        free_vec = ~valid_vec & ~barred;
    end

    logic             find_hit;
    logic [IDX_W-1:0] find_idx;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
    logic             avail_hit;
    logic [IDX_W-1:0] avail_idx;

    rsa_pri_enc #(.N(NUM_SLOTS)) u_enc_find (
        .i_req   (match_vec),
        .o_found (find_hit),
        .o_idx   (find_idx)
    );

    rsa_pri_enc #(.N(NUM_SLOTS)) u_enc_free (
        .i_req   (free_vec),
        .o_found (free_hit),
        .o_idx   (free_idx)
    );

    rsa_pri_enc #(.N(NUM_SLOTS)) u_enc_evict (
        .i_req   (~barred),
        .o_found (avail_hit),
        .o_idx   (avail_idx)
    );

    // Free slot first; otherwise evict the lowest unbarred slot.
    logic             alloc_hit;
    logic [IDX_W-1:0] alloc_idx;

    assign alloc_hit = free_hit || avail_hit;
    assign alloc_idx = free_hit ? free_idx : avail_idx;

    // ---------------------------------------------------------------- decode
    logic                  in_range;
    logic                  rd_valid;
    logic                  rd_dirty;
    logic [31:0]           node_ext;
    logic                  n_hit;
    logic [SLOT_W-1:0]     n_slot;
    logic [TAG_W-1:0]      n_node;
    logic                  n_dirty;

    assign in_range = ({1'b0, r_idx} < (SLOT_W + 1)'(NUM_SLOTS));
    assign rd_valid = in_range && valid_vec[r_idx[IDX_W-1:0]];
    assign rd_dirty = in_range && dirty_vec[r_idx[IDX_W-1:0]];

    always_comb begin
        node_ext                = '0;
        node_ext[NODE_BITS-1:0] = rd_node;
    end

    always_comb begin
        cmd           = '0;
        cmd.idx       = r_idx;
        cmd.evict_idx = SLOT_W'(avail_idx);
        cmd.dirty_val = r_din;
        n_hit         = 1'b0;
        n_slot        = '0;
        n_node        = '0;
        n_dirty       = 1'b0;
        if (r_req_valid) begin
            unique case (t_opcode'(r_op))
                OP_CLEAR:      cmd.clear_all  = 1'b1;
                OP_LOCK:       cmd.set_lock   = in_range;
                OP_UNLOCK:     cmd.clr_lock   = in_range;
                OP_FIND: begin
                    n_hit  = find_hit;
                    n_slot = SLOT_W'(find_idx);
                end
                OP_SET:        cmd.write_node = in_range;
                OP_GET: begin
                    n_hit  = rd_valid;
                    n_node = rd_valid ? node_ext[TAG_W-1:0] : '0;
                end
                OP_MARK_DIRTY: cmd.set_dirty  = in_range;
                OP_MARK_CLEAN: cmd.clr_dirty  = in_range;
                OP_QUERY:      n_dirty        = rd_dirty;
                OP_ALLOC: begin
                    cmd.evict = !free_hit && avail_hit;
                    n_hit     = alloc_hit;
                    n_slot    = alloc_hit ? SLOT_W'(alloc_idx) : '0;
                end
                OP_INVAL_VOL:  cmd.inval_vol  = 1'b1;
                default: begin
                    // Unused opcodes: no state change, all-zero result.
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- result
    logic                  r_valid;
    logic                  r_hit;
    logic [OUT_SLOT_W-1:0] r_slot;
    logic [TAG_W-1:0]      r_node;
    logic                  r_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_slot  <= n_slot[OUT_SLOT_W-1:0];
        r_node  <= n_node;
        r_dirty <= n_dirty;
    end

    assign o_valid     = r_valid;
    assign o_hit       = r_hit;
    assign o_slot_out  = r_slot;
    assign o_node_out  = r_node;
    assign o_dirty_out = r_dirty;

    // ---------------------------------------------------------------- checks
    `ASSERT_ALWAYS(a_no_result_after_reset, !i_rst_n |=> !o_valid, "result strobe after reset")
    `ASSERT_CLK(a_result_follows, (start && !busy) |-> ##2 o_valid, "accepted transaction lost")
    `ASSERT_CLK(a_alloc_not_locked, (r_req_valid && (r_op == OP_ALLOC) && alloc_hit) |-> !locked_vec[alloc_idx], "allocation picked a locked slot")
    `ASSERT_CLK(a_clear_empties, (r_req_valid && (r_op == OP_CLEAR)) |=> ((valid_vec == '0) && (locked_vec == '0) && (dirty_vec == '0)), "clear left slot state behind")

endmodule

`default_nettype wire

FILE: tb/sv/register_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// register_slot_allocator_tb
// Self-checking bench for the slot allocator. A directed opening covers the
// field extremes, every opcode and the out-of-range, no-match, fully barred,
// volatile-invalidate and spare-opcode cases. Randomized traffic follows,
// mixed with runs that fill the whole table and then allocate so that
// eviction is reached. A clocked predictor tracks the slot table and checks
// every result strobe against the oldest expected result.
// ----------------------------------------------------------------------------

module register_slot_allocator_tb;
    import rsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS      = 16;
    localparam int VOLATILE_COUNT = 6;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int IDLE_LIMIT     = 500;   // cycles with neither a request nor a result
    localparam int TAIL_CYCLES    = 4;     // margin after the last result is checked

    // Opcodes the block leaves unused; they must answer all zero.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd11;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SLOT_W-1:0]  idx;
        logic [TAG_W-1:0]   tag;
        logic               dirty;
        logic [AVOID_W-1:0] avoid;
        logic               drain;   // hold this one back until all results are in
    } t_slot_req;

    typedef struct packed {
        logic [OP_W-1:0]       op;   // kept for reporting only
        logic                  hit;
        logic [OUT_SLOT_W-1:0] slot;
        logic [TAG_W-1:0]      node;
        logic                  dirty;
    } t_slot_reply;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_opcode     = '0;
    logic [SLOT_W-1:0]     i_slot_index = '0;
    logic [TAG_W-1:0]      i_node_tag   = '0;
    logic                  i_dirty_in   = 1'b0;
    logic [AVOID_W-1:0]    i_avoid_mask = '0;
    logic                  o_valid;
    logic                  o_hit;
    logic [OUT_SLOT_W-1:0] o_slot_out;
    logic [TAG_W-1:0]      o_node_out;
    logic                  o_dirty_out;

    register_slot_allocator #(
        .NUM_SLOTS      (NUM_SLOTS),
        .VOLATILE_COUNT (VOLATILE_COUNT),
        .NODE_BITS      (16)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_slot_index (i_slot_index),
        .i_node_tag   (i_node_tag),
        .i_dirty_in   (i_dirty_in),
        .i_avoid_mask (i_avoid_mask),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_slot_out   (o_slot_out),
        .o_node_out   (o_node_out),
        .o_dirty_out  (o_dirty_out)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow copy of the slot table, advanced once per accepted transaction.
    // ------------------------------------------------------------------------
    logic [TAG_W-1:0] shadow_node  [NUM_SLOTS] = '{default: '0};
    logic             shadow_valid [NUM_SLOTS] = '{default: 1'b0};
    logic             shadow_lock  [NUM_SLOTS] = '{default: 1'b0};
    logic             shadow_dirty [NUM_SLOTS] = '{default: 1'b0};

    t_slot_req   request_q[$];   // stimulus not yet handed to the block
    t_slot_reply answer_q[$];    // results owed by the block, oldest first
    logic [TAG_W-1:0] tag_pool[8];

    int  total_items   = 0;
    int  accepted      = 0;
    int  fail_count    = 0;
    int  alloc_count   = 0;
    int  evict_count   = 0;
    int  barred_count  = 0;
    int  find_hits     = 0;
    int  idle_cycles   = 0;
    int  gap_left      = 0;
    int  calm_left     = 0;
    bit  taken         = 1'b0;

    function automatic void empty_slot(int i);
        shadow_valid[i] = 1'b0;
        shadow_node[i]  = '0;
        shadow_dirty[i] = 1'b0;
    endfunction

    // Work out the answer to one transaction and apply its side effects.
    function automatic t_slot_reply table_step(t_slot_req r);
        t_slot_reply a;
        logic        in_range;
        int          pick;
        a        = '0;
        a.op     = r.op;
        in_range = (r.idx < NUM_SLOTS);
        pick     = -1;
        case (t_opcode'(r.op))
            OP_CLEAR: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    empty_slot(i);
                    shadow_lock[i] = 1'b0;
                end
            end
            OP_LOCK:       if (in_range) shadow_lock[r.idx] = 1'b1;
            OP_UNLOCK:     if (in_range) shadow_lock[r.idx] = 1'b0;
            OP_FIND: begin
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                    if (shadow_valid[i] && shadow_node[i] == r.tag) pick = i;
                if (pick >= 0) begin
                    a.hit  = 1'b1;
                    a.slot = pick[OUT_SLOT_W-1:0];
                    find_hits++;
                end
            end
            OP_SET: begin
                if (in_range) begin
                    shadow_valid[r.idx] = 1'b1;
                    shadow_node[r.idx]  = r.tag;
                    shadow_dirty[r.idx] = r.dirty;
                end
            end
            OP_GET: begin
                if (in_range && shadow_valid[r.idx]) begin
                    a.hit  = 1'b1;
                    a.node = shadow_node[r.idx];
                end
            end
            OP_MARK_DIRTY: if (in_range) shadow_dirty[r.idx] = 1'b1;
            OP_MARK_CLEAN: if (in_range) shadow_dirty[r.idx] = 1'b0;
            OP_QUERY:      a.dirty = in_range && shadow_dirty[r.idx];
            OP_ALLOC: begin
                alloc_count++;
                // Prefer the lowest empty usable slot, else evict the lowest usable one.
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                    if (!shadow_valid[i] && !shadow_lock[i] && !r.avoid[i]) pick = i;
                if (pick < 0) begin
                    for (int i = NUM_SLOTS - 1; i >= 0; i--)
                        if (!shadow_lock[i] && !r.avoid[i]) pick = i;
                    if (pick >= 0) begin
                        empty_slot(pick);
                        evict_count++;
                    end
                end
                if (pick >= 0) begin
                    a.hit  = 1'b1;
                    a.slot = pick[OUT_SLOT_W-1:0];
                end else begin
                    barred_count++;
                end
            end
            OP_INVAL_VOL: begin
                for (int i = 0; i < VOLATILE_COUNT && i < NUM_SLOTS; i++)
                    empty_slot(i);
            end
            default: ;   // spare opcodes: no effect, all-zero answer
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_req(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx,
                            logic [TAG_W-1:0] tag, logic dirty,
                            logic [AVOID_W-1:0] avoid, logic drain);
        t_slot_req r;
        r = '{op: op, idx: idx, tag: tag, dirty: dirty, avoid: avoid, drain: drain};
        request_q.push_back(r);
        total_items++;
    endtask

    function automatic logic [TAG_W-1:0] pick_tag();
        if ($urandom_range(0, 99) < 70)
            return tag_pool[$urandom_range(0, 7)];
        return TAG_W'($urandom);
    endfunction

    function automatic logic [AVOID_W-1:0] pick_avoid();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return AVOID_W'($urandom);
            2: return ~(AVOID_W'(1) << $urandom_range(0, 15));   // only one slot allowed
            default: return AVOID_W'($urandom & $urandom & $urandom);
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] pick_index();
        if ($urandom_range(0, 99) < 85)
            return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        return SLOT_W'($urandom_range(NUM_SLOTS, 31));
    endfunction

    // Weighted opcode mix: sets and allocations dominate so the table fills up.
    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return OP_LOCK;
        if (r < 11) return OP_UNLOCK;
        if (r < 25) return OP_FIND;
        if (r < 47) return OP_SET;
        if (r < 57) return OP_GET;
        if (r < 62) return OP_MARK_DIRTY;
        if (r < 67) return OP_MARK_CLEAN;
        if (r < 75) return OP_QUERY;
        if (r < 93) return OP_ALLOC;
        if (r < 96) return OP_INVAL_VOL;
        if (r < 97) return OP_CLEAR;
        return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    // Fill every slot, then allocate against the full table to force eviction.
    task automatic push_fill_run(logic drain);
        for (int i = 0; i < NUM_SLOTS; i++)
            push_req(OP_SET, SLOT_W'(i), pick_tag(), 1'($urandom),
                     AVOID_W'($urandom), (i == 0) ? drain : 1'b0);
        repeat ($urandom_range(4, 8))
            push_req(OP_ALLOC, pick_index(), TAG_W'($urandom), 1'($urandom),
                     pick_avoid(), 1'b0);
    endtask

    // Sender gap after each transaction: mostly none, sometimes short, rarely
    // long, with calm stretches of back-to-back traffic.
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the next transaction at the falling edge, hold it
    // until the block takes it, then idle for the chosen gap.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_slot_req nxt;
        logic      go;
        logic      holding;
        go      = 1'b0;
        holding = start && !taken;
        if (i_rst_n && !holding) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (request_q.size() != 0 &&
                         !(request_q[0].drain && answer_q.size() != 0)) begin
                nxt      = request_q.pop_front();
                go       = 1'b1;
                gap_left = pick_gap();
            end
        end
        if (go) begin
            i_opcode     <= nxt.op;
            i_slot_index <= nxt.idx;
            i_node_tag   <= nxt.tag;
            i_dirty_in   <= nxt.dirty;
            i_avoid_mask <= nxt.avoid;
            start        <= 1'b1;
        end else if (!holding) begin
            start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check result strobes, predict accepted transactions and run
    // the idle watchdog, all at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_slot_reply want;
        t_slot_req   seen;
        taken = 1'b0;
        if (i_rst_n) begin
            idle_cycles++;
            if (o_valid) begin
                idle_cycles = 0;
                if (answer_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: hit %0b slot %0d node %h dirty %0b",
                                 o_hit, o_slot_out, o_node_out, o_dirty_out);
                end else begin
                    want = answer_q.pop_front();
                    if (o_hit !== want.hit || o_slot_out !== want.slot ||
                        o_node_out !== want.node || o_dirty_out !== want.dirty) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch op %0d: expected hit %0b slot %0d node %h dirty %0b",
                                     want.op, want.hit, want.slot, want.node, want.dirty);
                            $display("    actual hit %0b slot %0d node %h dirty %0b",
                                     o_hit, o_slot_out, o_node_out, o_dirty_out);
                        end
                    end
                end
            end
            if (start && !busy) begin
                idle_cycles = 0;
                taken       = 1'b1;
                accepted++;
                seen = '{op: i_opcode, idx: i_slot_index, tag: i_node_tag,
                         dirty: i_dirty_in, avoid: i_avoid_mask, drain: 1'b0};
                answer_q.push_back(table_step(seen));
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results owed",
                         IDLE_LIMIT, answer_q.size());
                $display("register_slot_allocator_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build all stimulus, release reset, wait for the queues to
    // drain, report.
    // ------------------------------------------------------------------------
    initial begin
        int target;
        tag_pool[0] = 16'h0000;
        tag_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            tag_pool[i] = TAG_W'($urandom);

        // Directed opening: extremes, every opcode, corner cases.
        push_req(OP_CLEAR,      5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_GET,        5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0);  // empty slot
        push_req(OP_QUERY,      5'd31, 16'h0000, 1'b0, 16'h0000, 1'b0);  // out of range
        push_req(OP_SET,        5'd0,  16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
        push_req(OP_SET,        5'd15, 16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_SET,        5'd31, 16'h1234, 1'b1, 16'h0000, 1'b0);  // ignored
        push_req(OP_GET,        5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_GET,        5'd15, 16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_GET,        5'd31, 16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_FIND,       5'd0,  16'hFFFF, 1'b0, 16'h0000, 1'b0);
        push_req(OP_FIND,       5'd31, 16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_FIND,       5'd0,  16'h1234, 1'b0, 16'h0000, 1'b0);  // no match
        push_req(OP_QUERY,      5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_MARK_CLEAN, 5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_QUERY,      5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_MARK_DIRTY, 5'd16, 16'h0000, 1'b0, 16'h0000, 1'b0);  // ignored
        push_req(OP_MARK_DIRTY, 5'd15, 16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_LOCK,       5'd1,  16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_ALLOC,      5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0);  // skips 0 and 1
        push_req(OP_ALLOC,      5'd0,  16'h0000, 1'b0, 16'hFFFF, 1'b0);  // all barred
        push_req(OP_UNLOCK,     5'd31, 16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_INVAL_VOL,  5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_GET,        5'd0,  16'h0000, 1'b0, 16'h0000, 1'b0);
        push_req(OP_SPARE_LO,   5'd31, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
        push_req(OP_SPARE_HI,   5'd7,  16'hA5A5, 1'b1, 16'h5A5A, 1'b0);

        // Random part; the first fill run also waits for the pipeline to empty.
        target = total_items + RANDOM_ITEMS;
        push_fill_run(1'b1);
        while (total_items < target) begin
            if ($urandom_range(0, 99) < 2)
                push_fill_run($urandom_range(0, 2) == 0);
            else
                push_req(pick_op(), pick_index(), pick_tag(), 1'($urandom),
                         pick_avoid(), 1'b0);
        end

        // Hold reset, then release it at a falling edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || start || answer_q.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("ran %0d transactions: %0d allocations, %0d evictions, %0d fully barred",
                 accepted, alloc_count, evict_count, barred_count);
        $display("find hits %0d, failures %0d", find_hits, fail_count);
        if (fail_count == 0)
            $display("register_slot_allocator_tb OK");
        else
            $display("register_slot_allocator_tb NOT OK");
        $finish;
    end

endmodule
